// ----- hdl/hex_dump_formatter_top_defines.svh -----
// assertion macros used by the hex dump formatter queue
`ifndef HEX_DUMP_FORMATTER_TOP_DEFINES_SVH
`define HEX_DUMP_FORMATTER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define HDF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hdf assertion failed");

// antecedent implies consequent in the next cycle
`define HDF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hdf assertion failed");

// expression holds at every edge
`define HDF_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("hdf assertion failed");

`else

`define HDF_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define HDF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define HDF_ASSERT_ALWAYS(lbl, clk, rst, expr)

`endif

`endif

// ----- hdl/hdf_pkg.sv -----
// shared types and constants of the hex dump formatter
package hdf_pkg;

   localparam int QUEUE_DEPTH = 4;

   // register indexes of the csr port
   localparam logic [1:0] CSR_UPPER_CASE  = 2'd0;
   localparam logic [1:0] CSR_UNIT_SIZE   = 2'd1;
   localparam logic [1:0] CSR_BLOCK_SIZE  = 2'd2;
   localparam logic [1:0] CSR_RECORD_SIZE = 2'd3;

   // separator that follows the two digits of a byte
   localparam logic [1:0] SEP_NONE    = 2'd0;
   localparam logic [1:0] SEP_SPACE   = 2'd1;
   localparam logic [1:0] SEP_SPACE2  = 2'd2;
   localparam logic [1:0] SEP_NEWLINE = 2'd3;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

   // one classified byte, ready to be spelled out
   typedef struct packed {
      logic [7:0] hi_char;
      logic [7:0] lo_char;
      logic [1:0] sep;
      logic       last;
   } hdf_entry_type;

endpackage

// ----- hdl/hdf_front.sv -----
// front end: takes bytes, runs the group counters and classifies each word
module hdf_front
   import hdf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          upper_case,
   input  logic [7:0]    unit_size,
   input  logic [7:0]    block_size,
   input  logic [7:0]    record_size,
   input  logic          accept,
   input  logic [7:0]    data_byte,
   input  logic          end_of_data,
   output hdf_entry_type entry
);

   logic [7:0] unit_count_ff, unit_count_in;
   logic [7:0] block_count_ff, block_count_in;
   logic [7:0] record_count_ff, record_count_in;
   logic [7:0] unit_bump, block_bump, record_bump;
   logic       record_hit, block_hit, unit_hit;

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
      logic [7:0] alpha_base;
      alpha_base = upper ? 8'h41 : 8'h61;
      if (nib < 4'd10) begin
         hex_char = 8'h30 + {4'd0, nib};
      end else begin
         hex_char = alpha_base + {4'd0, nib} - 8'd10;
      end
   endfunction

   function automatic logic [7:0] bump(input logic [7:0] count, input logic [7:0] size);
      if (size == 8'd0) begin
         bump = 8'd0;
      end else if (count == 8'hff) begin
         bump = count;
      end else begin
         bump = count + 8'd1;
      end
   endfunction

   always_comb begin
      record_bump = bump(record_count_ff, record_size);
      block_bump  = bump(block_count_ff, block_size);
      unit_bump   = bump(unit_count_ff, unit_size);

      record_hit = (record_size != 8'd0) && (record_bump >= record_size);
      block_hit  = (block_size != 8'd0) && (block_bump >= block_size);
      unit_hit   = (unit_size != 8'd0) && (unit_bump >= unit_size);

      entry.hi_char = hex_char(data_byte[7:4], upper_case);
      entry.lo_char = hex_char(data_byte[3:0], upper_case);
      entry.last    = end_of_data;

      record_count_in = record_bump;
      block_count_in  = block_bump;
      unit_count_in   = unit_bump;

      // record wins over block, block over unit
      if (record_hit) begin
         entry.sep       = SEP_NEWLINE;
         record_count_in = 8'd0;
         block_count_in  = 8'd0;
         unit_count_in   = 8'd0;
      end else if (block_hit) begin
         entry.sep      = SEP_SPACE2;
         block_count_in = 8'd0;
         unit_count_in  = 8'd0;
      end else if (unit_hit) begin
         entry.sep     = SEP_SPACE;
         unit_count_in = 8'd0;
      end else begin
         entry.sep = SEP_NONE;
      end

      if (end_of_data) begin
         record_count_in = 8'd0;
         block_count_in  = 8'd0;
         unit_count_in   = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_count_ff   <= 8'd0;
         block_count_ff  <= 8'd0;
         record_count_ff <= 8'd0;
      end else if (accept) begin
         unit_count_ff   <= unit_count_in;
         block_count_ff  <= block_count_in;
         record_count_ff <= record_count_in;
      end
   end

endmodule

// ----- hdl/hdf_queue.sv -----
// short queue of classified words between front and back
`include "hex_dump_formatter_top_defines.svh"

module hdf_queue
   import hdf_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  hdf_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output hdf_entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   hdf_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `HDF_ASSERT_ALWAYS(a_count_in_range, clock, reset, count_ff <= CNT_FULL)
   `HDF_ASSERT_IMPL(a_no_pop_empty, clock, reset, pop, head_valid)
   `HDF_ASSERT_IMPL(a_no_push_full, clock, reset, push && !pop, !full)
   `HDF_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// ----- hdl/hdf_back.sv -----
// back end: spells each queued word out one character per cycle while out_ready is high
module hdf_back
   import hdf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  hdf_entry_type head_entry,
   output logic          pop,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [7:0]    out_char,
   output logic          out_last
);

   logic [2:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic [1:0] sep_len;
   logic [2:0] final_step;
   logic       at_final;
   logic       load;
   logic [7:0] cur_char;

   always_comb begin
      case (head_entry.sep)
         SEP_NONE:    sep_len = 2'd0;
         SEP_SPACE:   sep_len = 2'd1;
         SEP_SPACE2:  sep_len = 2'd2;
         SEP_NEWLINE: sep_len = 2'd1;
         default:     sep_len = 2'd0;
      endcase
      final_step = 3'd1 + {1'b0, sep_len} + {2'd0, head_entry.last};
      at_final   = (step_ff == final_step);

      // steps past the separator are the trailing newline
      case (step_ff)
         3'd0: cur_char = head_entry.hi_char;
         3'd1: cur_char = head_entry.lo_char;
         3'd2: begin
            if (head_entry.sep == SEP_SPACE || head_entry.sep == SEP_SPACE2) begin
               cur_char = CHAR_SPACE;
            end else begin
               cur_char = CHAR_NEWLINE;
            end
         end
         3'd3: cur_char = (head_entry.sep == SEP_SPACE2) ? CHAR_SPACE : CHAR_NEWLINE;
         default: cur_char = CHAR_NEWLINE;
      endcase

      load = !valid_ff || out_ready;
      pop  = load && head_valid && at_final;

      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      step_in  = step_ff;
      if (load) begin
         valid_in = head_valid;
         char_in  = cur_char;
         last_in  = at_final;
         if (head_valid) begin
            step_in = at_final ? 3'd0 : step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule

// ----- hdl/hex_dump_formatter_top.sv -----
// hex dump formatter: bytes in, hex dump ascii characters out
//
// req_ channel: one byte per word, req_tlast marks the last byte of a buffer.
// rsp_ channel: one ascii character per word, rsp_tlast marks the last
// character produced by an input byte.
// each byte gives two hex digits, then at most one separator (one space,
// two spaces or a newline from the unit, block and record counters), then a
// newline if it was the last byte of the buffer: two to five characters.
// csr_ port: write upper_case, unit_size, block_size, record_size at any
// cycle while the block is idle; there is no read-back.
// an accepted byte is written into a queue slot, and its first character then
// goes through the output register onto rsp. the output register sends one
// character a cycle while rsp_tready is high.
// a four-word queue sits between the counter front end and the character
// back end, so req_tready stays high while rsp is stalled until it fills.
// reset clears counters, queue and output; registers return to their
// defaults (lower case, unit 1, block 8, record 16).
module hex_dump_formatter_top
   import hdf_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // end_of_data
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic       rsp_tlast,   // out_last
   input  logic       csr_we,
   input  logic [1:0] csr_addr,
   input  logic [7:0] csr_wdata
);

   logic          upper_case_ff;
   logic [7:0]    unit_size_ff;
   logic [7:0]    block_size_ff;
   logic [7:0]    record_size_ff;
   logic          req_accept;
   logic          queue_full;
   logic          queue_pop;
   logic          head_valid;
   hdf_entry_type front_entry;
   hdf_entry_type head_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_case_ff  <= 1'b0;
         unit_size_ff   <= 8'd1;
         block_size_ff  <= 8'd8;
         record_size_ff <= 8'd16;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_UPPER_CASE:  upper_case_ff  <= csr_wdata[0];
            CSR_UNIT_SIZE:   unit_size_ff   <= csr_wdata;
            CSR_BLOCK_SIZE:  block_size_ff  <= csr_wdata;
            CSR_RECORD_SIZE: record_size_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   hdf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .upper_case  (upper_case_ff),
      .unit_size   (unit_size_ff),
      .block_size  (block_size_ff),
      .record_size (record_size_ff),
      .accept      (req_accept),
      .data_byte   (req_tdata),
      .end_of_data (req_tlast),
      .entry       (front_entry)
   );

   hdf_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_entry (front_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   hdf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (queue_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_char   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule
